// ===== hdl/hsv2rgb_pkg.sv =====
// Shared types, widths and arithmetic helpers for the HSV to RGB converter.
// Used by every module of the block; depends on nothing else.
package hsv2rgb_pkg;

  // fixed-point format of the input fields
  localparam int FRAC_BITS = 15;
  localparam int FIELD_W   = 16;
  localparam int CH_W      = 8;
  localparam int FAC_W     = FRAC_BITS + 1;
  localparam int H6_W      = FIELD_W + 3;
  localparam int SECT_W    = H6_W - FRAC_BITS;
  localparam int PROD_W    = FIELD_W + FAC_W;
  localparam int SCL_W     = FIELD_W + CH_W;

  localparam logic [FIELD_W-1:0] ONE_FIELD = FIELD_W'(1) << FRAC_BITS;
  localparam logic [FAC_W-1:0]   ONE_FAC   = FAC_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0]    CH_MAX    = '1;

  // sector codes of the six-way color wheel
  localparam logic [SECT_W-1:0] SECT_RED_YEL = SECT_W'(0);
  localparam logic [SECT_W-1:0] SECT_YEL_GRN = SECT_W'(1);
  localparam logic [SECT_W-1:0] SECT_GRN_CYN = SECT_W'(2);
  localparam logic [SECT_W-1:0] SECT_CYN_BLU = SECT_W'(3);
  localparam logic [SECT_W-1:0] SECT_BLU_MAG = SECT_W'(4);

  // input beat
  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] brightness_value;
  } hsv_in_t;

  // result beat
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_out_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic               gray;
    logic [SECT_W-1:0]  sector;
    logic [FRAC_BITS-1:0] frac;
    logic [FIELD_W-1:0] sat;
    logic [FIELD_W-1:0] val;
    logic [FAC_W-1:0]   pfac;
  } hsv_cls_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
  } hsv_q_stat_t;

  // 1 - x, clamped at zero
  function automatic logic [FAC_W-1:0] one_minus(input logic [FIELD_W-1:0] x);
    logic [FIELD_W-1:0] diff;
    diff = ONE_FIELD - x;
    if (x >= ONE_FIELD) begin
      return '0;
    end
    return diff[FAC_W-1:0];
  endfunction

  // floor(x * 255), saturated to the channel range
  function automatic logic [CH_W-1:0] to_channel(input logic [FIELD_W-1:0] x);
    logic [SCL_W-1:0] prod;
    logic [SCL_W-FRAC_BITS-1:0] c;
    prod = {x, {CH_W{1'b0}}} - {{CH_W{1'b0}}, x};
    c = prod[SCL_W-1:FRAC_BITS];
    if (c > (SCL_W-FRAC_BITS)'(CH_MAX)) begin
      return CH_MAX;
    end
    return c[CH_W-1:0];
  endfunction

endpackage

// ===== hdl/hsv2rgb_front.sv =====
// Front end: takes an HSV beat, splits hue into sector and fraction, flags gray.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  hsv2rgb_pkg::hsv_in_t     hsv,
  input  hsv2rgb_pkg::hsv_q_stat_t q_stat,
  output logic                     busy,
  output logic                     push,
  output hsv2rgb_pkg::hsv_cls_t    entry
);
  import hsv2rgb_pkg::*;

  logic               f_valid;
  logic               f_valid_next;
  logic               accept;
  logic [H6_W-1:0]    h6;
  hsv_cls_t           cls;

  // handshake: hold off only while the staged item cannot enter the queue
  assign busy   = f_valid & q_stat.full;
  assign accept = start & ~busy;
  assign push   = f_valid & ~q_stat.full;

  // hue * 6 split into sector and fraction
  always_comb begin
    h6         = {2'b00, hsv.hue, 1'b0} + {1'b0, hsv.hue, 2'b00};
    cls.gray   = (hsv.saturation == '0);
    cls.sector = h6[H6_W-1:FRAC_BITS];
    cls.frac   = h6[FRAC_BITS-1:0];
    cls.sat    = hsv.saturation;
    cls.val    = hsv.brightness_value;
    cls.pfac   = one_minus(hsv.saturation);
  end

  // staging register valid
  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  // staging register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= cls;
    end
  end

  a_accept_stages: assert property (@(posedge clk) disable iff (rst)
    accept |=> f_valid)
    else $error("accepted beat not staged");

endmodule

// ===== hdl/hsv2rgb_queue.sv =====
// Two-entry queue between front and back end; drains one beat per cycle.
// Depends on hsv2rgb_pkg.
module hsv2rgb_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  hsv2rgb_pkg::hsv_cls_t    wr_entry,
  output hsv2rgb_pkg::hsv_q_stat_t q_stat,
  output logic                     rd_valid,
  output hsv2rgb_pkg::hsv_cls_t    rd_entry
);
  import hsv2rgb_pkg::*;

  hsv_cls_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  // back end never stalls, so pop whenever something is held
  assign pop          = (count != 2'd0);
  assign rd_valid     = pop;
  assign rd_entry     = slots[rd_ptr];
  assign q_stat.full  = (count == 2'd2);

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_drains: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3 && (count <= 2'd1))
    else $error("queue backed up though back end never stalls");

endmodule

// ===== hdl/hsv2rgb_back.sv =====
// Back end: three-stage datapath forming p, q, t and the channel selection.
// Depends on hsv2rgb_pkg.
module hsv2rgb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  hsv2rgb_pkg::hsv_cls_t in_entry,
  output logic                  strobe,
  output hsv2rgb_pkg::rgb_out_t rgb
);
  import hsv2rgb_pkg::*;

  // stage 1 registers
  logic               b1_vld;
  logic               b1_gray;
  logic [SECT_W-1:0]  b1_sector;
  logic [FIELD_W-1:0] b1_val;
  logic [FIELD_W-1:0] b1_sf;
  logic [FIELD_W-1:0] b1_sfc;
  logic [FIELD_W-1:0] b1_p;
  // stage 2 registers
  logic               b2_vld;
  logic               b2_gray;
  logic [SECT_W-1:0]  b2_sector;
  logic [FIELD_W-1:0] b2_val;
  logic [FIELD_W-1:0] b2_p;
  logic [FIELD_W-1:0] b2_q;
  logic [FIELD_W-1:0] b2_t;

  logic [PROD_W-1:0]  sf_prod;
  logic [PROD_W-1:0]  sfc_prod;
  logic [PROD_W-1:0]  p_prod;
  logic [FAC_W-1:0]   comp_f;
  logic [PROD_W-1:0]  q_prod;
  logic [PROD_W-1:0]  t_prod;
  logic [CH_W-1:0]    cv;
  logic [CH_W-1:0]    cp;
  logic [CH_W-1:0]    cq;
  logic [CH_W-1:0]    ct;
  rgb_out_t           rgb_next;

  // stage 1: s*f, s*(1-f), v*(1-s)
  always_comb begin
    comp_f   = ONE_FAC - {1'b0, in_entry.frac};
    sf_prod  = PROD_W'(in_entry.sat) * PROD_W'(in_entry.frac);
    sfc_prod = PROD_W'(in_entry.sat) * PROD_W'(comp_f);
    p_prod   = PROD_W'(in_entry.val) * PROD_W'(in_entry.pfac);
  end

  always_ff @(posedge clk) begin
    b1_gray   <= in_entry.gray;
    b1_sector <= in_entry.sector;
    b1_val    <= in_entry.val;
    b1_sf     <= sf_prod[FRAC_BITS +: FIELD_W];
    b1_sfc    <= sfc_prod[FRAC_BITS +: FIELD_W];
    b1_p      <= p_prod[FRAC_BITS +: FIELD_W];
  end

  // stage 2: q = v*(1-sf), t = v*(1-s(1-f))
  always_comb begin
    q_prod = PROD_W'(b1_val) * PROD_W'(one_minus(b1_sf));
    t_prod = PROD_W'(b1_val) * PROD_W'(one_minus(b1_sfc));
  end

  always_ff @(posedge clk) begin
    b2_gray   <= b1_gray;
    b2_sector <= b1_sector;
    b2_val    <= b1_val;
    b2_p      <= b1_p;
    b2_q      <= q_prod[FRAC_BITS +: FIELD_W];
    b2_t      <= t_prod[FRAC_BITS +: FIELD_W];
  end

  // stage 3: scale to 8 bits and route by sector
  always_comb begin
    cv = to_channel(b2_val);
    cp = to_channel(b2_p);
    cq = to_channel(b2_q);
    ct = to_channel(b2_t);
    if (b2_gray) begin
      rgb_next = '{red: cv, green: cv, blue: cv};
    end else begin
      unique case (b2_sector)
        SECT_RED_YEL: rgb_next = '{red: cv, green: ct, blue: cp};
        SECT_YEL_GRN: rgb_next = '{red: cq, green: cv, blue: cp};
        SECT_GRN_CYN: rgb_next = '{red: cp, green: cv, blue: ct};
        SECT_CYN_BLU: rgb_next = '{red: cp, green: cq, blue: cv};
        SECT_BLU_MAG: rgb_next = '{red: ct, green: cp, blue: cv};
        default:      rgb_next = '{red: cv, green: cp, blue: cq};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rgb <= rgb_next;
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      b1_vld <= in_valid;
      b2_vld <= b1_vld;
      strobe <= b2_vld;
    end
  end

  a_gray_equal: assert property (@(posedge clk) disable iff (rst)
    b2_vld && b2_gray |=> rgb.red == rgb.green && rgb.green == rgb.blue)
    else $error("gray beat gave unequal channels");

endmodule

// ===== hdl/hsv_to_rgb_converter_core.sv =====
// HSV to RGB converter: one beat in, one 8-bit RGB beat out.
// Each accepted beat passes the staging register, the queue and the three back-end stages before strobe rises.
// Throughput: one beat per clock; busy stays low because the back end never stalls.
// Reset (rst, synchronous, active high) empties the staging register, queue and pipe.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_queue, hsv2rgb_back.
module hsv_to_rgb_converter_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  hsv2rgb_pkg::hsv_in_t  hsv,
  output logic                  busy,
  output logic                  strobe,
  output hsv2rgb_pkg::rgb_out_t rgb
);
  import hsv2rgb_pkg::*;

  hsv_q_stat_t q_stat;
  hsv_cls_t    wr_entry;
  hsv_cls_t    rd_entry;
  logic        push;
  logic        rd_valid;

  // classify
  hsv2rgb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .hsv    (hsv),
    .q_stat (q_stat),
    .busy   (busy),
    .push   (push),
    .entry  (wr_entry)
  );

  // decouple
  hsv2rgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .q_stat   (q_stat),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

  // compute
  hsv2rgb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_entry (rd_entry),
    .strobe   (strobe),
    .rgb      (rgb)
  );

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("converter stalled input");

endmodule

// ===== test/tb_hsv_to_rgb_converter_core.sv =====
// Self-checking testbench for hsv_to_rgb_converter_core: table-driven and random HSV pixels,
// each output triple compared with a typed-in result or a bit-exact six-sector color model.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter_core RTL.
module tb_hsv_to_rgb_converter_core;
  import hsv2rgb_pkg::*;

  localparam longint unsigned UNITY     = longint'(1) << FRAC_BITS;
  localparam longint unsigned CH_SPAN   = 255;
  localparam longint unsigned HUE_STEPS = 6;
  localparam int              DRAIN_CAP = 64;
  localparam int              TAIL_CYC  = 8;
  localparam int              RAND_PER_PHASE = 430;

  // one row of the directed table; pinned rows carry their result typed in
  typedef struct packed {
    hsv_in_t  px;
    logic     pinned;
    rgb_out_t want;
  } pixel_row_t;

  localparam int N_ROWS = 24;

  pixel_row_t pixel_rows [N_ROWS] = '{
    // gray pixels and extremes, results read straight off the scheme
    '{'{16'd0,     16'd0,     16'd0},     1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd0,     16'd0,     16'd32768}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{16'd65535, 16'd0,     16'd65535}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{16'd12345, 16'd0,     16'd16384}, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{'{16'd0,     16'd32768, 16'd32768}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd65535, 16'd65535, 16'd65535}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd32768, 16'd32768, 16'd32768}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    // sector edges around the wheel
    '{'{16'd5461,  16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd5462,  16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd10923, 16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd16384, 16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd21845, 16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd21846, 16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd27307, 16'd32768, 16'd32768}, 1'b0, '0},
    '{'{16'd32767, 16'd32768, 16'd32768}, 1'b0, '0},
    // small and mid values
    '{'{16'd1,     16'd1,     16'd1},     1'b0, '0},
    '{'{16'd8000,  16'd16384, 16'd24000}, 1'b0, '0},
    '{'{16'd3000,  16'd32767, 16'd32767}, 1'b0, '0},
    '{'{16'd60000, 16'd1,     16'd32768}, 1'b0, '0},
    // saturation above one, value above one, hue above one
    '{'{16'd20000, 16'd40000, 16'd30000}, 1'b0, '0},
    '{'{16'd30000, 16'd20000, 16'd50000}, 1'b0, '0},
    '{'{16'd32768, 16'd65535, 16'd0},     1'b0, '0},
    '{'{16'd40000, 16'd32769, 16'd65535}, 1'b0, '0},
    '{'{16'd13107, 16'd65535, 16'd12345}, 1'b0, '0}
  };

  logic     clk;
  logic     rst;
  logic     start;
  hsv_in_t  hsv;
  logic     busy;
  logic     strobe;
  rgb_out_t rgb;

  // typed-in result for the beat currently on the input, if any
  logic     pin_valid;
  rgb_out_t pin_rgb;

  rgb_out_t rgb_due[$];
  int       n_fail;
  int       n_checked;
  int       n_sent;

  hsv_to_rgb_converter_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .hsv    (hsv),
    .busy   (busy),
    .strobe (strobe),
    .rgb    (rgb)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("hsv_to_rgb_converter_core regression: fail");
    $finish;
  end

  // complement against one, clamped at zero
  function automatic longint unsigned comp_one(input longint unsigned x);
    return (x >= UNITY) ? 64'd0 : UNITY - x;
  endfunction

  // fixed-point level to 8-bit channel, truncated and saturated
  function automatic logic [CH_W-1:0] level_to_ch(input longint unsigned x);
    longint unsigned c;
    c = (x * CH_SPAN) >> FRAC_BITS;
    return (c > CH_SPAN) ? CH_MAX : c[CH_W-1:0];
  endfunction

  // six-sector hsv to rgb, bit exact
  function automatic rgb_out_t hsv_pixel_to_rgb(input hsv_in_t px);
    longint unsigned   v;
    longint unsigned   s;
    longint unsigned   h6;
    longint unsigned   f;
    logic [SECT_W-1:0] sect;
    logic [CH_W-1:0]   cv;
    logic [CH_W-1:0]   cp;
    logic [CH_W-1:0]   cq;
    logic [CH_W-1:0]   ct;
    rgb_out_t          o;
    v  = px.brightness_value;
    s  = px.saturation;
    h6 = longint'(px.hue) * HUE_STEPS;
    cv = level_to_ch(v);
    if (s == 0) begin
      o = '{cv, cv, cv};
    end else begin
      sect = SECT_W'(h6 >> FRAC_BITS);
      f    = h6 & (UNITY - 1);
      cp   = level_to_ch((v * comp_one(s)) >> FRAC_BITS);
      cq   = level_to_ch((v * comp_one((s * f) >> FRAC_BITS)) >> FRAC_BITS);
      ct   = level_to_ch((v * comp_one((s * (UNITY - f)) >> FRAC_BITS)) >> FRAC_BITS);
      case (sect)
        SECT_RED_YEL: o = '{cv, ct, cp};
        SECT_YEL_GRN: o = '{cq, cv, cp};
        SECT_GRN_CYN: o = '{cp, cv, ct};
        SECT_CYN_BLU: o = '{cp, cq, cv};
        SECT_BLU_MAG: o = '{ct, cp, cv};
        default:      o = '{cv, cp, cq};
      endcase
    end
    return o;
  endfunction

  // send one beat, with a random gap first, and wait for it to be taken
  task automatic send_pixel(input hsv_in_t px, input logic pinned, input rgb_out_t want,
                            input int idle_pct);
    int gap;
    gap = (int'($urandom_range(0, 99)) < idle_pct) ? int'($urandom_range(1, 4)) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start     <= 1'b1;
    hsv       <= px;
    pin_valid = pinned;
    pin_rgb   = want;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // predict on every accepted beat, check on every result beat
  always @(posedge clk) begin : rgb_check
    rgb_out_t want;
    if (!rst) begin
      if (start && !busy) begin
        rgb_due.push_back(pin_valid ? pin_rgb : hsv_pixel_to_rgb(hsv));
      end
      if (strobe) begin
        if (rgb_due.size() == 0) begin
          $error("result beat %h with nothing expected", rgb);
          n_fail++;
        end else begin
          want = rgb_due.pop_front();
          n_checked++;
          if (rgb.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, rgb.red);
            n_fail++;
          end
          if (rgb.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, rgb.green);
            n_fail++;
          end
          if (rgb.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, rgb.blue);
            n_fail++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int       idle_pct [3];
    int       drained;
    int       mode;
    hsv_in_t  px;
    idle_pct  = '{0, 57, 37};
    n_fail    = 0;
    n_checked = 0;
    n_sent    = 0;
    rst       = 1'b1;
    start     = 1'b0;
    hsv       = '0;
    pin_valid = 1'b0;
    pin_rgb   = '0;

    // reset held at the start, then released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (pixel_rows[i]) begin
      send_pixel(pixel_rows[i].px, pixel_rows[i].pinned, pixel_rows[i].want, 0);
    end

    // random pixels, one phase per idle setting
    foreach (idle_pct[ph]) begin
      repeat (RAND_PER_PHASE) begin
        mode = $urandom_range(0, 9);
        px.hue              = FIELD_W'($urandom_range(0, 32768));
        px.saturation       = FIELD_W'($urandom_range(0, 32768));
        px.brightness_value = FIELD_W'($urandom_range(0, 32768));
        // gray pixels
        if (mode == 0) begin
          px.saturation = '0;
        end
        // whole field range, beyond one included
        if (mode == 1 || mode == 2) begin
          px = hsv_in_t'(48'({$urandom, $urandom}));
        end
        // full saturation and value, pure hues
        if (mode == 3) begin
          px.saturation       = ONE_FIELD;
          px.brightness_value = ONE_FIELD;
        end
        send_pixel(px, 1'b0, '0, idle_pct[ph]);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // drain the pipe, then watch for stray beats
    drained = 0;
    while (rgb_due.size() != 0 && drained < DRAIN_CAP) begin
      @(posedge clk);
      drained++;
    end
    repeat (TAIL_CYC) @(posedge clk);

    $display("sent %0d pixels (%0d table rows, rest random over gray, pure-hue and",
             n_sent, N_ROWS);
    $display("out-of-range fields at 0/57/37 percent idle), compared %0d rgb beats",
             n_checked);
    if (n_fail == 0 && rgb_due.size() == 0) begin
      $display("hsv_to_rgb_converter_core regression: pass");
    end else begin
      if (rgb_due.size() != 0) begin
        $error("%0d expected rgb beats never arrived", rgb_due.size());
      end
      $display("hsv_to_rgb_converter_core regression: fail");
    end
    $finish;
  end

endmodule
